// ===== rtl/apt_pkg.sv =====
package apt_pkg;

  // Operation codes of the input channel.
  typedef enum logic [2:0] {
    OP_ADD         = 3'd0,
    OP_REMOVE      = 3'd1,
    OP_FLUSH       = 3'd2,
    OP_CONTAINS    = 3'd3,
    OP_COUNT       = 3'd4,
    OP_FIND_DOMAIN = 3'd5,
    OP_GET_NTH     = 3'd6,
    OP_RESERVED    = 3'd7
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_MOD_WAIT,
    S_SCAN_RD,
    S_EVAL,
    S_LEN_WAIT,
    S_DONE
  } fsm_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [31:0] mark;
    logic [7:0]  proto;
    logic [31:0] address;
    logic [15:0] port_low;
    logic [15:0] port_high;
  } entry_t;

  // Latched input item.
  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] mark;
    logic [7:0]  proto;
    logic [31:0] address;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [31:0] index;
    logic [15:0] step;
    logic [15:0] domain_count;
  } in_item_t;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
    logic [15:0] remainder;
  } div_rsp_t;

  // Port sums are kept wide enough for a full table and saturated on output.
  localparam int          SUM_W     = 26;
  localparam logic [20:0] TOTAL_MAX = 21'h1FFFFF;

endpackage

// ===== rtl/apt_if.sv =====
// Input channel: one table operation per transfer.
interface apt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] mark;
  logic [7:0]  proto;
  logic [31:0] address;
  logic [15:0] port_low;
  logic [15:0] port_high;
  logic [31:0] index;
  logic [15:0] step;
  logic [15:0] domain_count;

  modport source (output valid, operation, mark, proto, address, port_low, port_high,
                  index, step, domain_count, input ready);
  modport sink (input valid, operation, mark, proto, address, port_low, port_high,
                index, step, domain_count, output ready);
endinterface

// Result channel: one result per operation.
interface apt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        hit;
  logic [31:0] result_address;
  logic [15:0] result_port;
  logic [20:0] total_ports;
  logic [15:0] group_size;

  modport source (output valid, status, hit, result_address, result_port, total_ports,
                  group_size, input ready);
  modport sink (input valid, status, hit, result_address, result_port, total_ports,
                group_size, output ready);
endinterface

// Configuration channel: writes the group size register.
interface apt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/address_port_pool_table.sv =====
// Ordered table of address and port range entries.
// in_ch carries one operation per transfer (add, remove, flush, contains,
// count, find_domain, get_nth); out_ch returns exactly one result per
// operation, in order. cfg_ch writes the ports-per-group register and is
// always ready; the user writes it only while the block is idle, which the
// block itself does not enforce. Entries sit in one memory with a registered
// read. A sequencer walks it one entry at a time, reading each entry and then
// evaluating it. add, flush and the reserved code finish without a walk.
// remove, contains, count and find_domain walk the used entries, find_domain
// stopping at its hit. get_nth first runs an iterative divider for the
// modulo, then runs the same divider again for the walk length of each
// walkable entry. One operation is worked on at a time.
// A finished result waits in the output register; the next operation is
// taken while it waits, and the sequencer holds at its end until the
// receiver takes the earlier result.
// Reset empties the table and sets the group size to one; no memory
// clearing pass is needed.
module address_port_pool_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input logic       clk,
  input logic       rst_n,
  apt_in_if.sink    in_ch,
  apt_out_if.source out_ch,
  apt_cfg_if.sink   cfg_ch
);
  import apt_pkg::*;

  localparam int            AW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int            CW      = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_ENTRIES);

  fsm_t              state_r, state_nxt;
  in_item_t          req_r;
  logic [15:0]       mpc_r;
  logic [CW-1:0]     used_r, used_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic              started_r, started_nxt;
  logic [15:0]       n_r, n_nxt;
  logic [15:0]       from_r, from_nxt;
  logic [31:0]       ent_addr_r, ent_addr_nxt;
  logic [47:0]       target_r, target_nxt;
  logic [SUM_W-1:0]  base_r, base_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  status_t           status_r, status_nxt;
  logic              hit_r, hit_nxt;
  logic [31:0]       raddr_r, raddr_nxt;
  logic [15:0]       rport_r, rport_nxt;
  logic [15:0]       gsize_r, gsize_nxt;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic              out_hit_r;
  logic [31:0]       out_raddr_r;
  logic [15:0]       out_rport_r;
  logic [20:0]       out_total_r;
  logic [15:0]       out_gsize_r;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  entry_t            e;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  entry_t            req_entry;
  logic [16:0]       len1_c;
  logic [16:0]       len_q_c;
  logic [15:0]       from_c;
  logic [31:0]       prod_c;
  logic              keep_c, last_c, match_c, walk_ok_c, found_c, n_lt_c, out_free_c;
  logic              in_fire, load_out;

  apt_mem #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (i_r[AW-1:0]),
    .rdata (e)
  );

  apt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Handshakes.
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free_c   = !out_valid_r || out_ch.ready;
  assign load_out     = (state_r == S_DONE) && out_free_c;

  // Per-entry tests on the entry just read.
  always_comb begin
    req_entry.mark      = req_r.mark;
    req_entry.proto     = req_r.proto;
    req_entry.address   = req_r.address;
    req_entry.port_low  = req_r.port_low;
    req_entry.port_high = req_r.port_high;
    len1_c    = (e.port_low <= e.port_high) ?
                ({1'b0, e.port_high} - {1'b0, e.port_low} + 17'd1) : 17'd0;
    keep_c    = (e != req_entry);
    last_c    = (i_r + 1'b1) == used_r;
    match_c   = (e.address == req_r.address) && (e.port_low <= req_r.port_low) &&
                (req_r.port_low <= e.port_high);
    from_c    = started_r ? e.port_low : req_r.port_low;
    walk_ok_c = (started_r || match_c) && (from_c <= e.port_high);
    found_c   = target_r < (48'(base_r) + 48'(len1_c));
    len_q_c   = div_rsp.quotient[16:0] + 17'd1;
    n_lt_c    = {1'b0, n_r} < len_q_c;
    prod_c    = n_r * req_r.step;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_START;
      end
      S_START: begin
        case (op_t'(req_r.operation))
          OP_REMOVE, OP_CONTAINS, OP_COUNT:
            state_nxt = (used_r == '0) ? S_DONE : S_SCAN_RD;
          OP_FIND_DOMAIN:
            state_nxt = (mpc_r == 16'd0 || used_r == '0) ? S_DONE : S_SCAN_RD;
          OP_GET_NTH:
            state_nxt = (req_r.step == 16'd0 || req_r.domain_count == 16'd0) ?
                        S_DONE : S_MOD_WAIT;
          default: state_nxt = S_DONE;
        endcase
      end
      S_MOD_WAIT: begin
        if (div_rsp.done) state_nxt = (used_r == '0) ? S_DONE : S_SCAN_RD;
      end
      S_SCAN_RD: state_nxt = S_EVAL;
      S_EVAL: begin
        case (op_t'(req_r.operation))
          OP_FIND_DOMAIN:
            state_nxt = (found_c || last_c) ? S_DONE : S_SCAN_RD;
          OP_GET_NTH:
            state_nxt = walk_ok_c ? S_LEN_WAIT : (last_c ? S_DONE : S_SCAN_RD);
          default:
            state_nxt = last_c ? S_DONE : S_SCAN_RD;
        endcase
      end
      S_LEN_WAIT: begin
        if (div_rsp.done) state_nxt = (n_lt_c || last_c) ? S_DONE : S_SCAN_RD;
      end
      S_DONE: begin
        if (out_free_c) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory writes and divider requests.
  always_comb begin
    used_nxt     = used_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    started_nxt  = started_r;
    n_nxt        = n_r;
    from_nxt     = from_r;
    ent_addr_nxt = ent_addr_r;
    target_nxt   = target_r;
    base_nxt     = base_r;
    sum_nxt      = sum_r;
    status_nxt   = status_r;
    hit_nxt      = hit_r;
    raddr_nxt    = raddr_r;
    rport_nxt    = rport_r;
    gsize_nxt    = gsize_r;
    mem_we       = 1'b0;
    mem_waddr    = j_r[AW-1:0];
    mem_wdata    = e;
    div_req      = '0;
    case (state_r)
      S_START: begin
        i_nxt       = '0;
        j_nxt       = '0;
        started_nxt = 1'b0;
        base_nxt    = '0;
        sum_nxt     = '0;
        hit_nxt     = 1'b0;
        raddr_nxt   = '0;
        rport_nxt   = '0;
        gsize_nxt   = '0;
        status_nxt  = ST_OK;
        target_nxt  = req_r.index * mpc_r;
        case (op_t'(req_r.operation))
          OP_ADD: begin
            if (req_r.port_low > req_r.port_high) begin
              status_nxt = ST_INVALID;
            end else if (used_r >= DEPTH_C) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = used_r[AW-1:0];
              mem_wdata = req_entry;
              used_nxt  = used_r + 1'b1;
            end
          end
          OP_FLUSH: used_nxt = '0;
          OP_REMOVE, OP_CONTAINS, OP_COUNT: status_nxt = ST_OK;
          OP_FIND_DOMAIN: status_nxt = (mpc_r == 16'd0) ? ST_INVALID : ST_NOT_FOUND;
          OP_GET_NTH: begin
            if (req_r.step == 16'd0 || req_r.domain_count == 16'd0) begin
              status_nxt = ST_INVALID;
            end else begin
              status_nxt       = ST_NOT_FOUND;
              div_req.start    = 1'b1;
              div_req.dividend = req_r.index;
              div_req.divisor  = req_r.domain_count;
            end
          end
          default: status_nxt = ST_INVALID;
        endcase
      end
      S_MOD_WAIT: begin
        if (div_rsp.done) n_nxt = div_rsp.remainder;
      end
      S_EVAL: begin
        i_nxt = i_r + 1'b1;
        case (op_t'(req_r.operation))
          OP_REMOVE: begin
            // Compact in place: kept entries move down to the write pointer.
            if (keep_c) begin
              mem_we = 1'b1;
              j_nxt  = j_r + 1'b1;
            end
            if (last_c) used_nxt = keep_c ? (j_r + 1'b1) : j_r;
          end
          OP_CONTAINS: begin
            if (e.proto == req_r.proto && e.address == req_r.address) hit_nxt = 1'b1;
          end
          OP_COUNT: sum_nxt = sum_r + SUM_W'(len1_c);
          OP_FIND_DOMAIN: begin
            if (found_c) begin
              status_nxt = ST_OK;
              raddr_nxt  = e.address;
              rport_nxt  = e.port_low + 16'(target_r - 48'(base_r));
              gsize_nxt  = mpc_r;
            end else begin
              base_nxt = base_r + SUM_W'(len1_c);
            end
          end
          OP_GET_NTH: begin
            if (started_r || match_c) started_nxt = 1'b1;
            // A walkable entry waits on the divider for its walk length.
            if (walk_ok_c) begin
              i_nxt            = i_r;
              from_nxt         = from_c;
              ent_addr_nxt     = e.address;
              div_req.start    = 1'b1;
              div_req.dividend = {16'd0, e.port_high - from_c};
              div_req.divisor  = req_r.step;
            end
          end
          default: i_nxt = i_r + 1'b1;
        endcase
      end
      S_LEN_WAIT: begin
        if (div_rsp.done) begin
          i_nxt = i_r + 1'b1;
          if (n_lt_c) begin
            status_nxt = ST_OK;
            raddr_nxt  = ent_addr_r;
            rport_nxt  = from_r + prod_c[15:0];
          end else begin
            n_nxt = n_r - len_q_c[15:0];
          end
        end
      end
      default: used_nxt = used_r;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      mpc_r       <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (cfg_ch.valid && cfg_ch.ready) mpc_r <= cfg_ch.data;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.operation    <= in_ch.operation;
      req_r.mark         <= in_ch.mark;
      req_r.proto        <= in_ch.proto;
      req_r.address      <= in_ch.address;
      req_r.port_low     <= in_ch.port_low;
      req_r.port_high    <= in_ch.port_high;
      req_r.index        <= in_ch.index;
      req_r.step         <= in_ch.step;
      req_r.domain_count <= in_ch.domain_count;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    started_r  <= started_nxt;
    n_r        <= n_nxt;
    from_r     <= from_nxt;
    ent_addr_r <= ent_addr_nxt;
    target_r   <= target_nxt;
    base_r     <= base_nxt;
    sum_r      <= sum_nxt;
    status_r   <= status_nxt;
    hit_r      <= hit_nxt;
    raddr_r    <= raddr_nxt;
    rport_r    <= rport_nxt;
    gsize_r    <= gsize_nxt;
    if (load_out) begin
      out_status_r <= status_r;
      out_hit_r    <= hit_r;
      out_raddr_r  <= raddr_r;
      out_rport_r  <= rport_r;
      out_total_r  <= (sum_r > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_r[20:0];
      out_gsize_r  <= gsize_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.hit            = out_hit_r;
  assign out_ch.result_address = out_raddr_r;
  assign out_ch.result_port    = out_rport_r;
  assign out_ch.total_ports    = out_total_r;
  assign out_ch.group_size     = out_gsize_r;

  // The fill count never passes the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DEPTH_C)
    else $error("fill count beyond table size");

  // The divider only runs while the sequencer waits on it.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> (state_r == S_MOD_WAIT || state_r == S_LEN_WAIT))
    else $error("divider busy outside a wait state");

  // Compaction never writes ahead of the entry being read.
  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_EVAL) |-> (j_r <= i_r))
    else $error("compaction write ahead of read pointer");

endmodule

// ===== rtl/apt_mem.sv =====
module apt_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  apt_pkg::entry_t  wdata,
  input  logic [AW-1:0]    raddr,
  output apt_pkg::entry_t  rdata
);
  import apt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/apt_div.sv =====
module apt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  apt_pkg::div_req_t req,
  output apt_pkg::div_rsp_t rsp
);
  import apt_pkg::*;

  logic [31:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] div_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] trial;
  logic        ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial   = {rem_r, quo_r[31]};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? 16'(trial - {1'b0, div_r}) : trial[15:0];
    quo_nxt = {quo_r[30:0], ge};
  end

  // Control: 32 steps per division, done pulses for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
